// ===== sv/lzd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared types and constants for the LZ78 stream decoder.
// ----------------------------------------------------------------------------
package lzd_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;   // entry length field, holds up to MAX_ENTRY_LEN + 1
  localparam int CODE_W = 16;  // full width of a received code

  // One decoded result on its way to the output register
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              err;
  } res_t;

endpackage

// ===== sv/lzd_ram.sv =====
// ----------------------------------------------------------------------------
// lzd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/lzd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lzd_ctrl
// Token parser and dictionary sequencer: builds entries, walks an entry's
// parent chain into the reverse stack and pops it out in order.
// ----------------------------------------------------------------------------
module lzd_ctrl #(
  parameter int DICT_ENTRIES  = 4096,
  parameter int MAX_ENTRY_LEN = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                in_start,
  input  logic                out_free,
  output lzd_pkg::res_t       res,
  // dictionary RAM
  output logic                          dict_we,
  output logic [$clog2(DICT_ENTRIES)-1:0] dict_waddr,
  output logic [$clog2(DICT_ENTRIES+1)+lzd_pkg::BYTE_W+lzd_pkg::LEN_W-1:0] dict_wdata,
  output logic [$clog2(DICT_ENTRIES)-1:0] dict_raddr,
  input  logic [$clog2(DICT_ENTRIES+1)+lzd_pkg::BYTE_W+lzd_pkg::LEN_W-1:0] dict_rdata,
  // reverse stack RAM
  output logic                           stk_we,
  output logic [$clog2(MAX_ENTRY_LEN)-1:0] stk_waddr,
  output logic [lzd_pkg::BYTE_W-1:0]     stk_wdata,
  output logic [$clog2(MAX_ENTRY_LEN)-1:0] stk_raddr,
  input  logic [lzd_pkg::BYTE_W-1:0]     stk_rdata
);
  import lzd_pkg::*;

  localparam int CW  = $clog2(DICT_ENTRIES + 1);
  localparam int AW  = $clog2(DICT_ENTRIES);
  localparam int SPW = $clog2(MAX_ENTRY_LEN + 1);
  localparam int SAW = $clog2(MAX_ENTRY_LEN);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_RD   = 4'b0100,
    S_POP  = 4'b1000
  } state_t;

  typedef enum logic [3:0] {
    PH_FIRST   = 4'b0001,
    PH_CODE_LO = 4'b0010,
    PH_CODE_HI = 4'b0100,
    PH_LITERAL = 4'b1000
  } phase_t;

  state_t           state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    prefix_r, prefix_nxt;
  logic [LEN_W-1:0] plen_r, plen_nxt;
  logic [7:0]       lo_r, lo_nxt;
  logic             hold_r, hold_nxt;
  logic [SPW-1:0]   sp_r, sp_nxt;

  logic             in_acc;
  phase_t           ph_eff;
  logic [CW-1:0]    cnt_eff;
  logic             hold_eff;
  logic [CW-1:0]    lit_prefix;
  logic [LEN_W-1:0] new_len;
  logic             full;
  logic [CODE_W-1:0] code;
  logic             code_go;
  logic             is_lit;

  logic [CW-1:0]    rd_parent;
  logic [BYTE_W-1:0] rd_byte;
  logic [LEN_W-1:0] rd_len;

  assign {rd_parent, rd_byte, rd_len} = dict_rdata;

  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;

  // a stream start resets the token state before the byte is decoded
  assign ph_eff   = in_start ? PH_FIRST : phase_r;
  assign cnt_eff  = in_start ? '0 : cnt_r;
  assign hold_eff = in_start ? 1'b0 : hold_r;

  assign is_lit     = (ph_eff == PH_FIRST) || (ph_eff == PH_LITERAL);
  assign lit_prefix = (ph_eff == PH_LITERAL) ? prefix_r : '0;
  assign new_len    = (lit_prefix == '0) ? LEN_W'(1) : plen_r + LEN_W'(1);
  assign full       = (cnt_eff == CW'(DICT_ENTRIES));
  assign code       = (ph_eff == PH_CODE_HI) ? {in_byte, lo_r} : CODE_W'(in_byte);

  assign stk_waddr = sp_r[SAW-1:0];
  assign stk_wdata = rd_byte;
  assign stk_raddr = SAW'(sp_r - SPW'(1));

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    prefix_nxt = prefix_r;
    plen_nxt   = plen_r;
    lo_nxt     = lo_r;
    hold_nxt   = hold_r;
    sp_nxt     = sp_r;
    res        = '0;
    dict_we    = 1'b0;
    dict_waddr = cnt_eff[AW-1:0];
    dict_wdata = {lit_prefix, in_byte, new_len};
    dict_raddr = AW'(code - CODE_W'(1));
    stk_we     = 1'b0;
    code_go    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          phase_nxt = ph_eff;
          cnt_nxt   = cnt_eff;
          hold_nxt  = hold_eff;
          if (!hold_eff) begin
            if (is_lit) begin
              phase_nxt = PH_CODE_LO;
              if (!full && (new_len > LEN_W'(MAX_ENTRY_LEN))) begin
                hold_nxt  = 1'b1;
                res.valid = 1'b1;
                res.last  = 1'b1;
                res.err   = 1'b1;
              end else begin
                if (!full) begin
                  dict_we = 1'b1;
                  cnt_nxt = cnt_eff + CW'(1);
                end
                res.valid = 1'b1;
                res.data  = in_byte;
                res.last  = 1'b1;
              end
            end else if ((ph_eff == PH_CODE_LO) && (cnt_eff > CW'(255))) begin
              lo_nxt    = in_byte;
              phase_nxt = PH_CODE_HI;
            end else begin
              code_go = 1'b1;
            end
          end
          if (code_go) begin
            phase_nxt  = PH_LITERAL;
            prefix_nxt = '0;
            if (code > CODE_W'(cnt_eff)) begin
              hold_nxt  = 1'b1;
              res.valid = 1'b1;
              res.last  = 1'b1;
              res.err   = 1'b1;
            end else if (code != '0) begin
              // read of code - 1 was issued on dict_raddr this cycle
              prefix_nxt = code[CW-1:0];
              sp_nxt     = '0;
              state_nxt  = S_WALK;
            end
          end
        end
      end
      S_WALK: begin
        stk_we = 1'b1;
        sp_nxt = sp_r + SPW'(1);
        if (sp_r == '0) begin
          plen_nxt = rd_len;
        end
        dict_raddr = AW'(rd_parent - CW'(1));
        if ((rd_parent == '0) || (sp_r + SPW'(1) == SPW'(MAX_ENTRY_LEN))) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_POP;
      end
      S_POP: begin
        if (out_free) begin
          res.valid = 1'b1;
          res.data  = stk_rdata;
          res.last  = (sp_r == SPW'(1));
          sp_nxt    = sp_r - SPW'(1);
          state_nxt = (sp_r == SPW'(1)) ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      phase_r  <= PH_FIRST;
      cnt_r    <= '0;
      prefix_r <= '0;
      hold_r   <= 1'b0;
      sp_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      prefix_r <= prefix_nxt;
      hold_r   <= hold_nxt;
      sp_r     <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plen_r <= plen_nxt;
    lo_r   <= lo_nxt;
  end

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> out_free)
    else $error("result produced while output register is occupied");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DICT_ENTRIES))
    else $error("entry count beyond dictionary size");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    dict_we |-> (cnt_eff < CW'(DICT_ENTRIES)))
    else $error("dictionary write while full");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (sp_r < SPW'(MAX_ENTRY_LEN)))
    else $error("reverse stack overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_RD) || (state_r == S_POP)) |-> (sp_r != '0))
    else $error("pop from empty reverse stack");

endmodule

// ===== sv/lz78_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// lz78_stream_decoder
// Byte-serial LZ78 decompressor with a RAM-based dictionary.
// ----------------------------------------------------------------------------
// Takes one compressed byte per input transaction (tuser = stream start) and
// returns decompressed bytes, tlast on the final byte caused by each input
// byte, tuser set on an error result. A literal byte or a code byte that
// gives no output is handled in S_IDLE alone. A nonzero code for an entry
// of length L walks the parent chain through the dictionary RAM (one read
// per cycle) into the reverse stack RAM, then pops each byte through S_RD
// and S_POP, S_POP waiting while the output register is occupied. The
// dictionary needs no clearing pass: the entry count bounds every read.
module lz78_stream_decoder #(
  parameter int DICT_ENTRIES  = 4096,
  parameter int MAX_ENTRY_LEN = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] comp_byte
  input  logic       in_tuser,   // [0] stream_start
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] data_byte
  output logic       out_tlast,
  output logic       out_tuser   // [0] error
);
  import lzd_pkg::*;

  localparam int CW  = $clog2(DICT_ENTRIES + 1);
  localparam int AW  = $clog2(DICT_ENTRIES);
  localparam int DW  = CW + BYTE_W + LEN_W;
  localparam int SAW = $clog2(MAX_ENTRY_LEN);

  res_t              res;
  logic              out_free;
  logic              dict_we;
  logic [AW-1:0]     dict_waddr, dict_raddr;
  logic [DW-1:0]     dict_wdata, dict_rdata;
  logic              stk_we;
  logic [SAW-1:0]    stk_waddr, stk_raddr;
  logic [BYTE_W-1:0] stk_wdata, stk_rdata;

  logic              vld_r;
  logic [BYTE_W-1:0] data_r;
  logic              last_r;
  logic              err_r;

  assign out_free = !vld_r || out_tready;

  lzd_ctrl #(
    .DICT_ENTRIES (DICT_ENTRIES),
    .MAX_ENTRY_LEN(MAX_ENTRY_LEN)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_start  (in_tuser),
    .out_free  (out_free),
    .res       (res),
    .dict_we   (dict_we),
    .dict_waddr(dict_waddr),
    .dict_wdata(dict_wdata),
    .dict_raddr(dict_raddr),
    .dict_rdata(dict_rdata),
    .stk_we    (stk_we),
    .stk_waddr (stk_waddr),
    .stk_wdata (stk_wdata),
    .stk_raddr (stk_raddr),
    .stk_rdata (stk_rdata)
  );

  // parent code, last byte and length of each entry
  lzd_ram #(
    .WIDTH(DW),
    .DEPTH(DICT_ENTRIES)
  ) u_dict (
    .clk    (clk),
    .wr_en  (dict_we),
    .wr_addr(dict_waddr),
    .wr_data(dict_wdata),
    .rd_addr(dict_raddr),
    .rd_data(dict_rdata)
  );

  lzd_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_ENTRY_LEN)
  ) u_stack (
    .clk    (clk),
    .wr_en  (stk_we),
    .wr_addr(stk_waddr),
    .wr_data(stk_wdata),
    .rd_addr(stk_raddr),
    .rd_data(stk_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (out_free) begin
      vld_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      data_r <= res.data;
      last_r <= res.last;
      err_r  <= res.err;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = err_r;

endmodule
